FILE: rtl/qph_pkg.sv
// shared constants and types for the quadratic probing hash table
package qph_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 11;
  localparam int KEY_BITS      = 16;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);

  // home slot reduction: quotient by reciprocal multiply, exact for every key
  localparam int     RECIP_SHIFT = KEY_BITS + SLOT_BITS;
  localparam int     RECIP_BITS  = KEY_BITS + 1;
  localparam longint RECIP_VAL   = ((longint'(1) << RECIP_SHIFT) + longint'(TABLE_ENTRIES)
                                    - longint'(1)) / longint'(TABLE_ENTRIES);
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  // per-slot status
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_GONE  = 2'd2
  } slot_st_e;

  // result codes
  typedef enum logic [2:0] {
    RES_INSERTED = 3'd0,
    RES_FULL     = 3'd1,
    RES_FOUND    = 3'd2,
    RES_MISSING  = 3'd3,
    RES_DELETED  = 3'd4
  } res_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_WAIT
  } qph_state_e;

  // one table entry as held in memory
  typedef struct packed {
    slot_st_e            st;
    logic [KEY_BITS-1:0] key;
  } entry_t;

endpackage

FILE: rtl/quadratic_probe_hash_table_core.sv
// open-addressing hash table with quadratic probing, one probe per cycle
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o | func_i, key_i
//  out     | output    | out_valid_o/out_stall_i | status_o, slot_o, probes_o
//
// a request passes through ST_MOD, ST_PROBE once per probe made (1..TABLE_ENTRIES)
// and ST_WAIT; the single read port of the entry memory sets the pace of one probe
// per cycle, and the home slot is formed in the cycle after the transfer (quotient
// by reciprocal multiply at the transfer, remainder next).
// reset clears the per-entry valid flags, so every slot reads as empty; no sweep.
// a finished result waits in the output register while the next request is taken.
module quadratic_probe_hash_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [qph_pkg::KEY_BITS-1:0]  key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [qph_pkg::SLOT_BITS-1:0] slot_o,
  output logic [qph_pkg::SLOT_BITS-1:0] probes_o
);
  import qph_pkg::*;

  localparam logic [SLOT_BITS:0]   ENTRIES_W  = (SLOT_BITS+1)'(TABLE_ENTRIES);
  localparam logic [SLOT_BITS-1:0] LAST_PROBE = SLOT_BITS'(TABLE_ENTRIES - 1);
  localparam int                   PROD_BITS  = RECIP_SHIFT + KEY_BITS;

  qph_state_e state_q, state_d;

  logic [1:0]           func_q, func_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [KEY_BITS-1:0]  quot_q, quot_d;
  logic [PROD_BITS-1:0] quot_prod;
  logic [KEY_BITS-1:0]  home_full;
  logic [SLOT_BITS-1:0] home_nx;
  logic [SLOT_BITS-1:0] slot_q, slot_d, slot_nx;
  logic [SLOT_BITS-1:0] probe_q, probe_d;
  logic [SLOT_BITS-1:0] delta_q, delta_d, delta_nx;
  logic [SLOT_BITS:0]   slot_sum;
  logic [SLOT_BITS:0]   delta_sum;

  res_e                 res_st_q, res_st_d;
  logic [SLOT_BITS-1:0] res_slot_q, res_slot_d;
  logic [SLOT_BITS-1:0] res_probe_q, res_probe_d;

  logic                 out_valid_q, out_valid_d, out_load;
  res_e                 out_st_q;
  logic [SLOT_BITS-1:0] out_slot_q, out_probe_q;

  // entry memory, per-entry valid flags, registered read
  entry_t               mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_wa, rd_addr;
  entry_t               mem_wd;
  entry_t               rd_word_q;
  logic                 rd_valid_q;
  slot_st_e             rd_st;
  logic                 key_hit;

  // home slot: quotient of the incoming key, remainder of the held key
  always_comb begin
    quot_prod = PROD_BITS'(key_i) * PROD_BITS'(RECIP);
    home_full = key_q - quot_q * KEY_BITS'(TABLE_ENTRIES);
    home_nx   = home_full[SLOT_BITS-1:0];
  end

  // next probe slot: offsets step by odd numbers, i*i -> (i+1)*(i+1)
  always_comb begin
    slot_sum  = {1'b0, slot_q} + {1'b0, delta_q};
    delta_sum = {1'b0, delta_q} + (SLOT_BITS+1)'(2);
    slot_nx   = (slot_sum >= ENTRIES_W) ? SLOT_BITS'(slot_sum - ENTRIES_W)
                                        : slot_sum[SLOT_BITS-1:0];
    delta_nx  = (delta_sum >= ENTRIES_W) ? SLOT_BITS'(delta_sum - ENTRIES_W)
                                         : delta_sum[SLOT_BITS-1:0];
  end

  // probed entry as seen by the controller
  assign rd_st   = rd_valid_q ? rd_word_q.st : SLOT_EMPTY;
  assign key_hit = (rd_word_q.key == key_q);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, memory access and result selection
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    quot_d      = quot_q;
    slot_d      = slot_q;
    probe_d     = probe_q;
    delta_d     = delta_q;
    res_st_d    = res_st_q;
    res_slot_d  = res_slot_q;
    res_probe_d = res_probe_q;
    rd_addr     = slot_nx;
    mem_we      = 1'b0;
    mem_wa      = slot_q;
    mem_wd      = '{st: SLOT_USED, key: key_q};
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          key_d   = key_i;
          quot_d  = quot_prod[RECIP_SHIFT +: KEY_BITS];
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        rd_addr = home_nx;
        slot_d  = home_nx;
        probe_d = '0;
        delta_d = SLOT_BITS'(1);
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (func_q == OP_INSERT) begin
          if (rd_st != SLOT_USED) begin
            mem_we      = 1'b1;
            res_st_d    = RES_INSERTED;
            res_slot_d  = slot_q;
            res_probe_d = probe_q;
            state_d     = ST_WAIT;
          end else if (probe_q == LAST_PROBE) begin
            res_st_d    = RES_FULL;
            res_slot_d  = '0;
            res_probe_d = LAST_PROBE;
            state_d     = ST_WAIT;
          end
        end else begin
          if (rd_st == SLOT_EMPTY) begin
            res_st_d    = RES_MISSING;
            res_slot_d  = '0;
            res_probe_d = probe_q;
            state_d     = ST_WAIT;
          end else if (rd_st == SLOT_USED && key_hit) begin
            res_slot_d  = slot_q;
            res_probe_d = probe_q;
            state_d     = ST_WAIT;
            if (func_q == OP_DELETE) begin
              mem_we   = 1'b1;
              mem_wd   = '{st: SLOT_GONE, key: key_q};
              res_st_d = RES_DELETED;
            end else begin
              res_st_d = RES_FOUND;
            end
          end else if (probe_q == LAST_PROBE) begin
            res_st_d    = RES_MISSING;
            res_slot_d  = '0;
            res_probe_d = LAST_PROBE;
            state_d     = ST_WAIT;
          end
        end
        // keep probing: the next read is already issued at slot_nx
        if (state_d == ST_PROBE) begin
          slot_d  = slot_nx;
          probe_d = probe_q + SLOT_BITS'(1);
          delta_d = delta_nx;
        end
      end
      ST_WAIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // request and probe datapath
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    key_q       <= key_d;
    quot_q      <= quot_d;
    slot_q      <= slot_d;
    probe_q     <= probe_d;
    delta_q     <= delta_d;
    res_st_q    <= res_st_d;
    res_slot_q  <= res_slot_d;
    res_probe_q <= res_probe_d;
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_word_q <= mem_q[rd_addr];
  end

  // valid flags: an entry never written reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[mem_wa] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  // output register
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q    <= res_st_q;
      out_slot_q  <= res_slot_q;
      out_probe_q <= res_probe_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign slot_o      = out_slot_q;
  assign probes_o    = out_probe_q;

  // probe index and slot stay inside the table
  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROBE |-> (probe_q <= LAST_PROBE) && (slot_q <= LAST_PROBE))
    else $error("probe index or slot out of range");

  // a memory write always ends the request
  a_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> state_q == ST_WAIT)
    else $error("memory written without ending the request");

  // results without a slot report slot zero
  a_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == RES_FULL || status_o == RES_MISSING) |-> slot_o == '0)
    else $error("miss or full result carries a slot");

  // a new result is loaded only once the previous one has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("output result overwritten before transfer");

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the quadratic probing hash table core
`timescale 1ns / 1ps

module tb_top;
  import qph_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASES         = 15;
  localparam int PHASE_ITEMS    = 40;

  // expected result of one request
  typedef struct packed {
    res_e                 st;
    logic [SLOT_BITS-1:0] slot;
    logic [SLOT_BITS-1:0] probes;
  } hash_result_t;

  // one directed request, with its result typed in where it is obvious
  typedef struct packed {
    op_e                 op;
    logic [KEY_BITS-1:0] key;
    logic                typed;
    hash_result_t        want;
  } table_req_t;

  // operation mix of a random phase
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           func_i = OP_INSERT;
  logic [KEY_BITS-1:0]  key_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [2:0]           status_o;
  logic [SLOT_BITS-1:0] slot_o;
  logic [SLOT_BITS-1:0] probes_o;

  // shadow copy of the table contents
  logic [KEY_BITS-1:0] shadow_key [TABLE_ENTRIES];
  slot_st_e            shadow_st  [TABLE_ENTRIES];

  hash_result_t pending_results [$];
  table_req_t   directed_reqs [$];
  hash_result_t oldest;

  int err_count   = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  int hold_reqs   = 0;
  int hold_served = 0;
  bit quiet       = 1'b0;

  quadratic_probe_hash_table_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .probes_o    (probes_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // walk the probe sequence of one request and update the shadow table
  task automatic hash_apply(input op_e op, input logic [KEY_BITS-1:0] key,
                            output hash_result_t r);
    int  home;
    int  idx;
    bit  done;
    home     = key % TABLE_ENTRIES;
    done     = 1'b0;
    r.st     = (op == OP_INSERT) ? RES_FULL : RES_MISSING;
    r.slot   = '0;
    r.probes = SLOT_BITS'(TABLE_ENTRIES - 1);
    for (int i = 0; i < TABLE_ENTRIES && !done; i++) begin
      idx = (home + i * i) % TABLE_ENTRIES;
      if (op == OP_INSERT) begin
        if (shadow_st[idx] != SLOT_USED) begin
          shadow_key[idx] = key;
          shadow_st[idx]  = SLOT_USED;
          r.st            = RES_INSERTED;
          r.slot          = SLOT_BITS'(idx);
          r.probes        = SLOT_BITS'(i);
          done            = 1'b1;
        end
      end else if (shadow_st[idx] == SLOT_EMPTY) begin
        r.probes = SLOT_BITS'(i);
        done     = 1'b1;
      end else if (shadow_st[idx] == SLOT_USED && shadow_key[idx] == key) begin
        if (op == OP_DELETE) begin
          shadow_st[idx] = SLOT_GONE;
          r.st           = RES_DELETED;
        end else begin
          r.st = RES_FOUND;
        end
        r.slot   = SLOT_BITS'(idx);
        r.probes = SLOT_BITS'(i);
        done     = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // add a row to the directed table
  task automatic add_req(input op_e op, input logic [KEY_BITS-1:0] key, input bit typed,
                         input res_e st, input int slot, input int probes);
    table_req_t row;
    row.op          = op;
    row.key         = key;
    row.typed       = typed;
    row.want.st     = st;
    row.want.slot   = SLOT_BITS'(slot);
    row.want.probes = SLOT_BITS'(probes);
    directed_reqs.push_back(row);
  endtask

  // offer one request after a random gap; called and returns at a falling edge
  task automatic send_req(input op_e op, input logic [KEY_BITS-1:0] key, input bit typed,
                          input hash_result_t want);
    int           gap;
    hash_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_i      <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hash_apply(op, key, predicted);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  function automatic op_e pick_op(input mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 60) return OP_INSERT;
        if (r < 85) return OP_SEARCH;
        if (r < 95) return OP_DELETE;
      end
      MIX_DRAIN: begin
        if (r < 15) return OP_INSERT;
        if (r < 40) return OP_SEARCH;
        if (r < 95) return OP_DELETE;
      end
      default: begin
        if (r < 35) return OP_INSERT;
        if (r < 65) return OP_SEARCH;
        if (r < 95) return OP_DELETE;
      end
    endcase
    return OP_SPARE;
  endfunction

  // mostly colliding keys or keys already held, some fully random
  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    int idx;
    int homes [3];
    homes = '{0, 3, 7};
    r     = $urandom_range(0, 99);
    if (r < 30) begin
      idx = $urandom_range(0, TABLE_ENTRIES - 1);
      if (shadow_st[idx] == SLOT_USED) return shadow_key[idx];
    end
    if (r < 80) return KEY_BITS'(homes[$urandom_range(0, 2)] + TABLE_ENTRIES * $urandom_range(0, 5));
    return KEY_BITS'($urandom);
  endfunction

  // check each result transfer and draw the next receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        oldest = pending_results.pop_front();
        if (status_o !== oldest.st) report_mismatch("status", status_o, oldest.st);
        if (slot_o !== oldest.slot) report_mismatch("slot", slot_o, oldest.slot);
        if (probes_o !== oldest.probes) report_mismatch("probes", probes_o, oldest.probes);
      end
      stall_left = quiet ? 0 : $urandom_range(0, 9);
    end
  end

  // receiver stall, with long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_served != hold_reqs) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    mix_e         mix;
    hash_result_t none;
    none = '0;
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      shadow_key[s] = '0;
      shadow_st[s]  = SLOT_EMPTY;
    end

    // directed rows: empty table, key extremes, a full collision chain
    add_req(OP_SEARCH, 16'h0000, 1'b1, RES_MISSING, 0, 0);
    add_req(OP_DELETE, 16'hFFFF, 1'b1, RES_MISSING, 0, 0);
    add_req(OP_INSERT, 16'h0000, 1'b1, RES_INSERTED, 0, 0);
    add_req(OP_INSERT, 16'hFFFF, 1'b1, RES_INSERTED, 8, 0);
    add_req(OP_SEARCH, 16'hFFFF, 1'b1, RES_FOUND, 8, 0);
    add_req(OP_SPARE, 16'h0000, 1'b1, RES_FOUND, 0, 0);
    add_req(OP_INSERT, 16'd11, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_INSERT, 16'd22, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_INSERT, 16'd33, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_INSERT, 16'd44, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_INSERT, 16'd55, 1'b0, RES_INSERTED, 0, 0);
    // every slot on the probe path of home 0 is taken now
    add_req(OP_INSERT, 16'd66, 1'b1, RES_FULL, 0, TABLE_ENTRIES - 1);
    add_req(OP_SEARCH, 16'd77, 1'b1, RES_MISSING, 0, TABLE_ENTRIES - 1);
    // tombstones are skipped by search and reused by insert
    add_req(OP_DELETE, 16'd22, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_SEARCH, 16'd55, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_INSERT, 16'd77, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_DELETE, 16'd11, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_SEARCH, 16'd11, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_SEARCH, 16'h5555, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_INSERT, 16'hAAAA, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_DELETE, 16'hAAAA, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_DELETE, 16'h0000, 1'b0, RES_INSERTED, 0, 0);
    add_req(OP_SPARE, 16'd2, 1'b0, RES_INSERTED, 0, 0);

    // reset
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < directed_reqs.size(); n++) begin
      send_req(directed_reqs[n].op, directed_reqs[n].key, directed_reqs[n].typed,
               directed_reqs[n].want);
    end

    // sender pause until the block has drained
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);

    // random phases of fill, drain and even mixes
    for (int p = 0; p < PHASES; p++) begin
      mix   = mix_e'(p % 3);
      quiet = (p % 4 == 3) || (p == 5);
      if (p == 5) hold_reqs++;
      if (p == 10) begin
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_req(pick_op(mix), pick_key(), 1'b0, none);
      end
    end

    // wait for the last results
    in_valid_i <= 1'b0;
    quiet      = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
